FILE: rtl/brx_pkg.sv
// Package for the backward RLE executable decompressor: types, codes and helpers.
package brx_pkg;

    localparam int ADDR_W        = 21;
    localparam int COUNT_W       = 16;
    localparam int BYTE_W        = 8;
    localparam int MAX_IMAGE_DEF = 1048576;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [BYTE_W-1:0] OP_FILL     = 8'hB0;
    localparam logic [BYTE_W-1:0] OP_FILL_END = 8'hB1;
    localparam logic [BYTE_W-1:0] OP_COPY     = 8'hB2;
    localparam logic [BYTE_W-1:0] OP_COPY_END = 8'hB3;
    localparam logic [BYTE_W-1:0] OP_PAD      = 8'hFF;

    localparam logic [1:0] CFG_CLEN = 2'd0;
    localparam logic [1:0] CFG_ULEN = 2'd1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_EXHAUSTED = 2'd1;
    localparam logic [1:0] ERR_SPACE     = 2'd2;
    localparam logic [1:0] ERR_OPCODE    = 2'd3;

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_CNT_HI  = 3'd1,
        PH_CNT_LO  = 3'd2,
        PH_FILL    = 3'd3,
        PH_LITERAL = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BYTE_W-1:0]  value;
        logic [COUNT_W-1:0] len;
        logic [ADDR_W-1:0]  dest;
        logic [1:0]         err;
    } t_result;

    typedef struct packed {
        logic    valid_a;
        t_result res_a;
        logic    valid_b;
        t_result res_b;
    } t_push;

    function automatic t_result mk_status(logic [1:0] kind, logic [ADDR_W-1:0] dest,
                                          logic [1:0] err);
        t_result r;
        r.kind  = kind;
        r.value = '0;
        r.len   = '0;
        r.dest  = dest;
        r.err   = err;
        return r;
    endfunction

    function automatic t_result mk_write(logic [BYTE_W-1:0] value, logic [COUNT_W-1:0] len,
                                         logic [ADDR_W-1:0] dest);
        t_result r;
        r.kind  = KIND_WRITE;
        r.value = value;
        r.len   = len;
        r.dest  = dest;
        r.err   = ERR_NONE;
        return r;
    endfunction

endpackage

FILE: rtl/brx_decode.sv
// Command decoder: parses one compressed byte per request and produces result requests.
module brx_decode
    import brx_pkg::*;
#(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output t_push             o_push
);

    t_phase              r_phase, n_phase;
    logic [1:0]          r_kind, n_kind;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0]   r_in_rem, n_in_rem;
    logic [ADDR_W-1:0]   r_wp, n_wp;
    logic [ADDR_W-1:0]   r_clen, n_clen;
    logic [ADDR_W-1:0]   r_ulen, n_ulen;
    logic [ADDR_W-1:0]   clamped;

    always_comb begin
        if ({{(32-ADDR_W){1'b0}}, i_cfg_data} > 32'(MAX_IMAGE_BYTES)) begin
            clamped = ADDR_W'(MAX_IMAGE_BYTES);
        end else begin
            clamped = i_cfg_data;
        end
    end

    always_comb begin
        logic [ADDR_W-1:0]  rem_d;
        logic [ADDR_W-1:0]  wp_new;
        logic [COUNT_W-1:0] cnt;
        logic               do_finish;
        logic               do_fail;
        logic [1:0]         fail_code;

        n_phase  = r_phase;
        n_kind   = r_kind;
        n_count  = r_count;
        n_in_rem = r_in_rem;
        n_wp     = r_wp;
        n_clen   = r_clen;
        n_ulen   = r_ulen;
        o_push   = '0;
        rem_d    = r_in_rem - ADDR_W'(1);
        wp_new   = r_wp;
        cnt      = {r_count[COUNT_W-1:BYTE_W], i_byte};
        do_finish = 1'b0;
        do_fail   = 1'b0;
        fail_code = ERR_NONE;

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_CLEN) begin
                n_clen = clamped;
            end else if (i_cfg_index == CFG_ULEN) begin
                n_ulen = clamped;
            end
            if (i_cfg_index == CFG_CLEN || i_cfg_index == CFG_ULEN) begin
                n_phase  = PH_OPCODE;
                n_kind   = '0;
                n_count  = '0;
                n_in_rem = (i_cfg_index == CFG_CLEN) ? clamped : r_clen;
                n_wp     = (i_cfg_index == CFG_ULEN) ? clamped : r_ulen;
            end
        end else if (i_accept && r_phase != PH_DONE && r_phase != PH_ERROR) begin
            if (r_in_rem == '0) begin
                do_fail   = 1'b1;
                fail_code = ERR_EXHAUSTED;
            end else begin
                n_in_rem = rem_d;
                unique case (r_phase)
                    PH_OPCODE: begin
                        if (i_byte >= OP_FILL && i_byte <= OP_COPY_END) begin
                            n_kind = 2'(i_byte - OP_FILL);
                            if (rem_d < ADDR_W'(2)) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_EXHAUSTED;
                            end else begin
                                n_phase = PH_CNT_HI;
                            end
                        end else if (i_byte == OP_PAD && r_wp == r_ulen) begin
                            if (rem_d == '0) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_EXHAUSTED;
                            end
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = ERR_OPCODE;
                        end
                    end
                    PH_CNT_HI: begin
                        n_count = {i_byte, {BYTE_W{1'b0}}};
                        n_phase = PH_CNT_LO;
                    end
                    PH_CNT_LO: begin
                        n_count = cnt;
                        if (r_wp < {{(ADDR_W-COUNT_W){1'b0}}, cnt}) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_SPACE;
                        end else if (!r_kind[1]) begin
                            if (rem_d == '0) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_EXHAUSTED;
                            end else begin
                                n_phase = PH_FILL;
                            end
                        end else if (rem_d < {{(ADDR_W-COUNT_W){1'b0}}, cnt}) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_EXHAUSTED;
                        end else if (cnt == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase = PH_LITERAL;
                        end
                    end
                    PH_FILL: begin
                        if (r_count != '0) begin
                            wp_new         = r_wp - {{(ADDR_W-COUNT_W){1'b0}}, r_count};
                            o_push.valid_a = 1'b1;
                            o_push.res_a   = mk_write(i_byte, r_count, wp_new);
                        end
                        n_wp      = wp_new;
                        do_finish = 1'b1;
                    end
                    PH_LITERAL: begin
                        wp_new         = r_wp - ADDR_W'(1);
                        n_wp           = wp_new;
                        o_push.valid_a = 1'b1;
                        o_push.res_a   = mk_write(i_byte, COUNT_W'(1), wp_new);
                        n_count        = r_count - COUNT_W'(1);
                        if (r_count == COUNT_W'(1)) begin
                            do_finish = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_ERROR;
                    end
                endcase
            end

            if (do_finish) begin
                if (r_kind[0]) begin
                    n_phase        = PH_DONE;
                    o_push.valid_b = 1'b1;
                    o_push.res_b   = mk_status(KIND_DONE, wp_new, ERR_NONE);
                end else if (rem_d == '0) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_EXHAUSTED;
                end else begin
                    n_phase = PH_OPCODE;
                end
            end

            if (do_fail) begin
                n_phase        = PH_ERROR;
                o_push.valid_b = 1'b1;
                o_push.res_b   = mk_status(KIND_ERROR, wp_new, fail_code);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_kind   <= '0;
            r_count  <= '0;
            r_in_rem <= '0;
            r_wp     <= '0;
            r_clen   <= '0;
            r_ulen   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_count  <= n_count;
            r_in_rem <= n_in_rem;
            r_wp     <= n_wp;
            r_clen   <= n_clen;
            r_ulen   <= n_ulen;
        end
    end

`ifndef SYNTH
    a_wp_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> r_wp <= $past(r_wp))
        else $error("write pointer moved up without a config write");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid_b && !i_cfg_we) |=> (r_phase == PH_DONE || r_phase == PH_ERROR))
        else $error("status result without terminal phase");
`endif

endmodule

FILE: rtl/brx_out_queue.sv
// Output queue: takes up to two result requests per cycle, hands out one per cycle while i_pop is high.
module brx_out_queue
    import brx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_near_full,
    output t_result o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  n_push;
    t_result           first;
    logic              pop_ok;

    assign o_valid     = (r_cnt != '0);
    assign o_near_full = (r_cnt > CNT_W'(QUEUE_DEPTH - 2));
    assign o_head      = r_mem[r_rptr];
    assign pop_ok      = i_pop && o_valid;
    assign first       = i_push.valid_a ? i_push.res_a : i_push.res_b;

    always_comb begin
        n_push = CNT_W'(i_push.valid_a) + CNT_W'(i_push.valid_b);
        n_wptr = r_wptr + PTR_W'(n_push);
        n_rptr = r_rptr + PTR_W'(pop_ok);
        n_cnt  = r_cnt + n_push - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid_a || i_push.valid_b) begin
            r_mem[r_wptr] <= first;
        end
        if (i_push.valid_a && i_push.valid_b) begin
            r_mem[r_wptr + PTR_W'(1)] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cnt) + 32'(n_push)) <= 32'(QUEUE_DEPTH))
        else $error("output queue overflow");
`endif

endmodule

FILE: rtl/backward_rle_exe_decompressor.sv
// Top level of the backward RLE executable decompressor.
// Accepts one compressed byte per cycle unless o_in_stall is high, last byte first,
// with no idle steps for any command: the decoder handles each byte in a single
// registered step and fill runs are reported as descriptors. One byte yields zero,
// one or two result requests, which are written into a four-entry output queue;
// the queue drains one request per cycle while i_out_stall is low, and the input
// stalls while fewer than two entries are free. Config writes are always ready; a
// write to either length register restarts decoding, and writes to other indexes
// are ignored.
module backward_rle_exe_decompressor
    import brx_pkg::*;
#(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [ADDR_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_out_kind,
    output logic [BYTE_W-1:0]  o_fill_value,
    output logic [COUNT_W-1:0] o_run_length,
    output logic [ADDR_W-1:0]  o_dest_low,
    output logic [1:0]         o_error_code
);

    t_push   push;
    t_result head;
    logic    near_full;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = near_full;
    assign accept      = i_in_valid && !near_full;

    brx_decode #(
        .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_data_byte),
        .o_push      (push)
    );

    brx_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (!i_out_stall),
        .o_valid     (o_out_valid),
        .o_near_full (near_full),
        .o_head      (head)
    );

    assign o_out_kind   = head.kind;
    assign o_fill_value = head.value;
    assign o_run_length = head.len;
    assign o_dest_low   = head.dest;
    assign o_error_code = head.err;

endmodule

FILE: verif/backward_rle_exe_decompressor_checker.sv
// Result checker for the backward RLE decompressor: tracks decode state and compares results.
module backward_rle_exe_decompressor_checker
    import brx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [ADDR_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_out_kind,
    input  logic [BYTE_W-1:0]  i_fill_value,
    input  logic [COUNT_W-1:0] i_run_length,
    input  logic [ADDR_W-1:0]  i_dest_low,
    input  logic [1:0]         i_error_code,
    output int                 o_fail_count,
    output int                 o_backlog
);

    logic [ADDR_W-1:0]  clen_reg;
    logic [ADDR_W-1:0]  ulen_reg;
    logic [ADDR_W-1:0]  bytes_left;
    logic [ADDR_W-1:0]  wr_ptr;
    logic [COUNT_W-1:0] pend_cnt;
    logic [1:0]         cmd_kind;
    t_phase             phase;
    t_result            expected_runs[$];
    int                 fails = 0;

    function automatic logic [ADDR_W-1:0] saturate(input logic [ADDR_W-1:0] v);
        return (v > ADDR_W'(MAX_IMAGE_DEF)) ? ADDR_W'(MAX_IMAGE_DEF) : v;
    endfunction

    task automatic restart_decode();
        phase      = PH_OPCODE;
        cmd_kind   = '0;
        pend_cnt   = '0;
        bytes_left = clen_reg;
        wr_ptr     = ulen_reg;
    endtask

    task automatic push_status(input logic [1:0] kind, input logic [1:0] err);
        t_result r;
        r.kind  = kind;
        r.value = '0;
        r.len   = '0;
        r.dest  = wr_ptr;
        r.err   = err;
        expected_runs.push_back(r);
        phase = (kind == KIND_ERROR) ? PH_ERROR : PH_DONE;
    endtask

    task automatic push_run(input logic [BYTE_W-1:0] value, input logic [COUNT_W-1:0] len);
        t_result r;
        r.kind  = KIND_WRITE;
        r.value = value;
        r.len   = len;
        r.dest  = wr_ptr;
        r.err   = ERR_NONE;
        expected_runs.push_back(r);
    endtask

    task automatic end_command();
        if (cmd_kind[0])
            push_status(KIND_DONE, ERR_NONE);
        else if (bytes_left == 0)
            push_status(KIND_ERROR, ERR_EXHAUSTED);
        else
            phase = PH_OPCODE;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        if (phase == PH_DONE || phase == PH_ERROR)
            return;
        if (bytes_left == 0) begin
            push_status(KIND_ERROR, ERR_EXHAUSTED);
            return;
        end
        bytes_left = bytes_left - 1'b1;
        case (phase)
            PH_OPCODE: begin
                if (b >= OP_FILL && b <= OP_COPY_END) begin
                    cmd_kind = 2'(b - OP_FILL);
                    if (bytes_left < 2)
                        push_status(KIND_ERROR, ERR_EXHAUSTED);
                    else
                        phase = PH_CNT_HI;
                end else if (b == OP_PAD && wr_ptr == ulen_reg) begin
                    if (bytes_left == 0)
                        push_status(KIND_ERROR, ERR_EXHAUSTED);
                end else begin
                    push_status(KIND_ERROR, ERR_OPCODE);
                end
            end
            PH_CNT_HI: begin
                pend_cnt = {b, 8'h00};
                phase    = PH_CNT_LO;
            end
            PH_CNT_LO: begin
                pend_cnt[7:0] = b;
                if (wr_ptr < pend_cnt)
                    push_status(KIND_ERROR, ERR_SPACE);
                else if (!cmd_kind[1]) begin
                    if (bytes_left < 1)
                        push_status(KIND_ERROR, ERR_EXHAUSTED);
                    else
                        phase = PH_FILL;
                end else if (bytes_left < pend_cnt)
                    push_status(KIND_ERROR, ERR_EXHAUSTED);
                else if (pend_cnt == 0)
                    end_command();
                else
                    phase = PH_LITERAL;
            end
            PH_FILL: begin
                if (pend_cnt != 0) begin
                    wr_ptr = wr_ptr - pend_cnt;
                    push_run(b, pend_cnt);
                end
                end_command();
            end
            PH_LITERAL: begin
                wr_ptr = wr_ptr - 1'b1;
                push_run(b, 16'd1);
                pend_cnt = pend_cnt - 1'b1;
                if (pend_cnt == 0)
                    end_command();
            end
            default: phase = PH_ERROR;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_runs.size() == 0) begin
            $error("unexpected result request: kind %0d, dest %0d", i_out_kind, i_dest_low);
            fails++;
        end else begin
            want = expected_runs.pop_front();
            compare_field("out_kind", 32'(want.kind), 32'(i_out_kind));
            compare_field("fill_value", 32'(want.value), 32'(i_fill_value));
            compare_field("run_length", 32'(want.len), 32'(i_run_length));
            compare_field("dest_low", 32'(want.dest), 32'(i_dest_low));
            compare_field("error_code", 32'(want.err), 32'(i_error_code));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clen_reg = '0;
            ulen_reg = '0;
            restart_decode();
            expected_runs.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CLEN) begin
                    clen_reg = saturate(i_cfg_data);
                    restart_decode();
                end else if (i_cfg_index == CFG_ULEN) begin
                    ulen_reg = saturate(i_cfg_data);
                    restart_decode();
                end
            end
            if (i_in_valid && !i_in_stall)
                decode_byte(i_data_byte);
        end
        o_backlog    <= expected_runs.size();
        o_fail_count <= fails;
    end

endmodule

FILE: verif/backward_rle_exe_decompressor_test.sv
// Testbench top for the backward RLE decompressor: clock, reset, stimulus and verdict.
module backward_rle_exe_decompressor_test;
    import brx_pkg::*;

    localparam logic [1:0]        CFG_SPARE_LO = 2'd2;
    localparam logic [1:0]        CFG_SPARE_HI = 2'd3;
    localparam int                RANDOM_BYTES = 1500;
    localparam logic [ADDR_W-1:0] LEN_MAX      = ADDR_W'(MAX_IMAGE_DEF);
    localparam logic [ADDR_W-1:0] LEN_ONES     = '1;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index  = '0;
    logic [ADDR_W-1:0]  i_cfg_data   = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_data_byte  = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [1:0]         o_out_kind;
    logic [BYTE_W-1:0]  o_fill_value;
    logic [COUNT_W-1:0] o_run_length;
    logic [ADDR_W-1:0]  o_dest_low;
    logic [1:0]         o_error_code;

    int                 fail_count;
    int                 backlog;
    bit                 calm = 1'b0;
    int                 bytes_sent = 0;
    logic [BYTE_W-1:0]  stream_bytes[$];

    backward_rle_exe_decompressor uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_kind   (o_out_kind),
        .o_fill_value (o_fill_value),
        .o_run_length (o_run_length),
        .o_dest_low   (o_dest_low),
        .o_error_code (o_error_code)
    );

    backward_rle_exe_decompressor_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_kind   (o_out_kind),
        .i_fill_value (o_fill_value),
        .i_run_length (o_run_length),
        .i_dest_low   (o_dest_low),
        .i_error_code (o_error_code),
        .o_fail_count (fail_count),
        .o_backlog    (backlog)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("backward_rle_exe_decompressor test failed");
        $finish;
    end

    function automatic bit roll_gap();
        return !calm && ($urandom_range(0, 99) < 31);
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= roll_gap();
    end

    task automatic write_reg(input logic [1:0] index, input logic [ADDR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (roll_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // all requests in, nothing outstanding, then a short settle
    task automatic wait_quiet();
        do @(posedge i_clk); while (backlog != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_stream(input logic [ADDR_W-1:0] clen, input logic [ADDR_W-1:0] ulen);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_CLEN, clen);
            write_reg(CFG_ULEN, ulen);
        end else begin
            write_reg(CFG_ULEN, ulen);
            write_reg(CFG_CLEN, clen);
        end
        foreach (stream_bytes[k])
            send_byte(stream_bytes[k]);
        i_in_valid <= 1'b0;
        wait_quiet();
    endtask

    task automatic build_stream(output logic [ADDR_W-1:0] clen, output logic [ADDR_W-1:0] ulen);
        int unsigned n_cmd;
        int unsigned cnt;
        int unsigned written;
        int unsigned pick;
        int unsigned i;
        logic [BYTE_W-1:0] op;
        stream_bytes.delete();
        written = 0;
        if ($urandom_range(0, 14) == 0) begin
            repeat ($urandom_range(1, 6))
                stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            clen = ADDR_W'($urandom_range(0, 8));
            ulen = ADDR_W'($urandom_range(0, 64));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) stream_bytes.push_back(OP_PAD);
        n_cmd = $urandom_range(1, 5);
        for (i = 0; i < n_cmd; i++) begin
            if ($urandom_range(0, 1)) begin
                op = (i == n_cmd - 1) ? OP_FILL_END : OP_FILL;
                case ($urandom_range(0, 3))
                    0: cnt = 0;
                    1: cnt = $urandom_range(0, 65535);
                    default: cnt = $urandom_range(1, 40);
                endcase
            end else begin
                op  = (i == n_cmd - 1) ? OP_COPY_END : OP_COPY;
                cnt = $urandom_range(0, 6);
            end
            stream_bytes.push_back(op);
            stream_bytes.push_back(BYTE_W'(cnt >> 8));
            stream_bytes.push_back(BYTE_W'(cnt));
            if (op == OP_FILL || op == OP_FILL_END)
                stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            else
                repeat (cnt) stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            written += cnt;
        end

        pick = $urandom_range(0, 19);
        if (pick == 0)
            ulen = LEN_MAX;
        else if (pick < 3 && written > 0)
            ulen = ADDR_W'(written - $urandom_range(1, written));
        else if (pick < 6)
            ulen = ADDR_W'(written + $urandom_range(0, 5000));
        else
            ulen = ADDR_W'(written + $urandom_range(0, 3));

        clen = ADDR_W'(stream_bytes.size());
        pick = $urandom_range(0, 19);
        if (pick == 0)
            clen = ADDR_W'($urandom_range(0, stream_bytes.size() - 1));
        else if (pick == 1)
            stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] =
                BYTE_W'($urandom_range(0, 255));
        else if (pick == 2)
            clen = clen + ADDR_W'($urandom_range(1, 4));
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2))
                stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned       stream_no;
        logic [ADDR_W-1:0] clen;
        logic [ADDR_W-1:0] ulen;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lengths still zero from reset
        send_byte(8'h00);
        i_in_valid <= 1'b0;
        wait_quiet();

        // unused indexes, saturated lengths, filler then a maximal final run
        write_reg(CFG_SPARE_LO, LEN_ONES);
        write_reg(CFG_SPARE_HI, 21'h0AAAAA);
        stream_bytes = {OP_PAD, OP_FILL_END, 8'hFF, 8'hFF, 8'h00};
        run_stream(LEN_ONES, LEN_ONES);

        // zero-count run, then final literals at the byte extremes
        stream_bytes = {OP_FILL, 8'h00, 8'h00, 8'h77, OP_COPY_END, 8'h00, 8'h02, 8'hFF, 8'h00};
        run_stream(21'd9, 21'd6);

        // filler after output is a bad opcode
        stream_bytes = {OP_FILL, 8'h00, 8'h02, 8'h11, OP_PAD};
        run_stream(21'd5, 21'd10);

        // count exceeds space
        stream_bytes = {OP_COPY, 8'h00, 8'h03};
        run_stream(21'd3, 21'd2);

        // shortages: after opcode, before fill byte, before literals, after command, after filler
        stream_bytes = {OP_FILL};
        run_stream(21'd2, 21'd4);
        stream_bytes = {OP_FILL, 8'h00, 8'h05};
        run_stream(21'd3, 21'd9);
        stream_bytes = {OP_COPY, 8'h00, 8'h03};
        run_stream(21'd5, 21'd9);
        stream_bytes = {OP_FILL, 8'h00, 8'h01, 8'hAA};
        run_stream(21'd4, 21'd9);
        stream_bytes = {OP_PAD};
        run_stream(21'd1, 21'd0);

        stream_bytes = {8'h42};
        run_stream(21'd3, 21'd0);

        stream_no = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            calm = (stream_no >= 20 && stream_no < 32);
            build_stream(clen, ulen);
            bytes_sent += stream_bytes.size();
            run_stream(clen, ulen);
            stream_no++;
        end
        calm = 1'b0;
        wait_quiet();

        if (fail_count == 0)
            $display("backward_rle_exe_decompressor test passed");
        else
            $display("backward_rle_exe_decompressor test failed");
        $finish;
    end

endmodule
